/* hw/rtl/flptm_pkg.sv */
// Package for the four-level page table mapper.
// Constants, state and command types shared by controller, datapath and top.
package flptm_pkg;
  localparam int TableFrames = 64;
  localparam int EntriesPerTable = 512;
  localparam int SlotW = $clog2(TableFrames);
  localparam int IdxW = 9;
  localparam int AddrW = SlotW + IdxW;
  localparam int FrameW = 40;
  localparam int CntW = 13;

  localparam logic [1:0] CfgRoot = 2'd0;
  localparam logic [1:0] CfgBase = 2'd1;
  localparam logic [1:0] CfgFirst = 2'd2;
  localparam logic [1:0] CfgCount = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoFrame = 2'd1;
  localparam logic [1:0] StOutside = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CLRROOT, S_CHECK, S_READ, S_EVAL, S_CLEAR, S_LINK, S_DONE
  } state_t;

  typedef struct packed {
    logic load;      // latch input transaction, level 0, frame = root
    logic rd;        // issue read of current entry
    logic wr_leaf;   // write leaf entry
    logic wr_or;     // write existing entry ORed with upper bits
    logic wr_new;    // write entry pointing to new frame, advance allocator
    logic clr_start; // start clearing pass on new frame (clr_root: root slot 0)
    logic clr_root;
    logic clr_step;
    logic next_lvl;
    logic reset_used;
  } cmd_t;

  typedef struct packed {
    logic query;
    logic last;        // level 3
    logic slot_ok;     // current frame in store
    logic present;     // read entry present
    logic alloc_ok;    // frames remain
    logic new_ok;      // new frame in store
    logic clr_done;
  } sts_t;
endpackage

/* hw/rtl/four_level_page_table_mapper_top.sv */
// Top level of the four-level page table mapper.
// Depends on flptm_pkg, flptm_ctrl and flptm_dpath.
//
// Use: write registers on cfg_ (index 0 root_frame, 1 store_base_frame,
// 2 alloc_first_frame, 3 alloc_frame_count) while idle. Each in_ transaction
// is a map (action 0) or query (action 1) of one virtual page and yields one
// out_ transaction with status and mapped.
// Flow: one item at a time; each level walked takes a check, a store read
// and an evaluation, and a check that finds a table outside the store ends
// the walk. out_valid is registered from the controller's result strobe.
// Each newly allocated table first takes a clearing pass over its 512 entries,
// one entry a cycle through the single store write port, then a step that
// links it into its parent.
// Reset: a clearing pass over its 512 entries zeroes store slot 0, the root
// table at reset; in_ready stays low during it, cfg writes are taken throughout.
// Stall: the result waits in the output register and in_ready stays low
// until it is taken; an item is accepted in the cycle the result is taken.
module four_level_page_table_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [35:0] in_virt_page,
  input  logic [39:0] in_phys_frame,
  input  logic [11:0] in_entry_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_mapped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);
  import flptm_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic res_load, res_mapped;
  logic [1:0] res_status;
  logic out_free;
  logic [39:0] root_r, base_r, first_r;
  logic [12:0] count_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      base_r <= '0;
      first_r <= 40'd1;
      count_r <= 13'd63;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgRoot: root_r <= cfg_data;
        CfgBase: base_r <= cfg_data;
        CfgFirst: first_r <= cfg_data;
        CfgCount: count_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (res_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= res_status;
      out_mapped <= res_mapped;
    end
  end

  flptm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .res_load, .res_status, .res_mapped,
    .out_free, .sts, .cmd
  );

  flptm_dpath u_dpath (
    .clk, .rst_n, .cmd, .sts, .in_action, .in_virt_page, .in_phys_frame,
    .in_entry_flags, .root_frame(root_r), .store_base_frame(base_r),
    .alloc_first_frame(first_r), .alloc_frame_count(count_r)
  );

  a_res_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !in_ready) else $error("result while accepting");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !res_load || !$past(res_load))
    else $error("result overwritten");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
endmodule

/* hw/rtl/flptm_ctrl.sv */
// Controller state machine of the page table mapper.
// Depends on flptm_pkg; drives the datapath through cmd_t, reads sts_t.
module flptm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             res_load,
  output logic [1:0]       res_status,
  output logic             res_mapped,
  input  logic             out_free,
  input  flptm_pkg::sts_t  sts,
  output flptm_pkg::cmd_t  cmd
);
  import flptm_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLRROOT;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    res_status = StOk;
    res_mapped = 1'b0;
    unique case (state_r)
      S_CLRROOT: begin
        cmd.clr_root = 1'b1;
        cmd.clr_step = 1'b1;
        cmd.reset_used = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.slot_ok) begin
          res_status = StOutside;
          state_nxt = S_DONE;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_DONE;
        if (sts.query) begin
          if (sts.present && sts.last) res_mapped = 1'b1;
          else if (sts.present) begin
            cmd.next_lvl = 1'b1;
            state_nxt = S_CHECK;
          end
        end else if (sts.last) begin
          cmd.wr_leaf = 1'b1;
        end else if (sts.present) begin
          cmd.wr_or = 1'b1;
          cmd.next_lvl = 1'b1;
          state_nxt = S_CHECK;
        end else if (!sts.alloc_ok) begin
          res_status = StNoFrame;
        end else if (!sts.new_ok) begin
          res_status = StOutside;
        end else begin
          cmd.clr_start = 1'b1;
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_LINK;
      end
      S_LINK: begin
        cmd.wr_new = 1'b1;
        cmd.next_lvl = 1'b1;
        state_nxt = S_CHECK;
      end
      S_DONE: ;
      default: state_nxt = S_IDLE;
    endcase
    if (state_nxt == S_DONE && state_r != S_DONE) res_load = 1'b1;
    if (state_r == S_DONE) begin
      if (out_free) state_nxt = S_IDLE;
    end else if (res_load && out_free) begin
      state_nxt = S_IDLE;
    end
  end
endmodule

/* hw/rtl/flptm_dpath.sv */
// Datapath of the page table mapper: table store, walk registers, allocator.
// Depends on flptm_pkg; controlled by flptm_ctrl through cmd_t.
module flptm_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  flptm_pkg::cmd_t           cmd,
  output flptm_pkg::sts_t           sts,
  input  logic                      in_action,
  input  logic [35:0]               in_virt_page,
  input  logic [39:0]               in_phys_frame,
  input  logic [11:0]               in_entry_flags,
  input  logic [39:0]               root_frame,
  input  logic [39:0]               store_base_frame,
  input  logic [39:0]               alloc_first_frame,
  input  logic [12:0]               alloc_frame_count
);
  import flptm_pkg::*;
  logic [63:0] mem [TableFrames*EntriesPerTable];
  logic [63:0] rdata_r;
  logic query_r;
  logic [35:0] vp_r;
  logic [39:0] pf_r;
  logic [11:0] fl_r;
  logic [1:0] lvl_r;
  logic [39:0] frame_r;
  logic [CntW-1:0] used_r;
  logic [SlotW-1:0] clr_slot_r;
  logic [IdxW-1:0] clr_idx_r;
  logic clr_done;

  logic [39:0] off, new_frame, new_off, nxt_frame;
  logic [IdxW-1:0] idx;
  logic [AddrW-1:0] addr;
  logic [63:0] upper, wdata;
  logic we;
  logic [AddrW-1:0] waddr;

  assign off = frame_r - store_base_frame;
  assign sts.slot_ok = (frame_r >= store_base_frame) && (off < 40'(TableFrames));
  assign new_frame = alloc_first_frame + 40'(used_r);
  assign new_off = new_frame - store_base_frame;
  assign sts.new_ok = (new_frame >= store_base_frame) && (new_off < 40'(TableFrames));
  assign sts.alloc_ok = used_r < alloc_frame_count;
  assign sts.query = query_r;
  assign sts.last = (lvl_r == 2'd3);
  assign sts.present = rdata_r[0];
  assign clr_done = (clr_idx_r == '1);
  assign sts.clr_done = clr_done;

  always_comb begin
    case (lvl_r)
      2'd0: idx = vp_r[35:27];
      2'd1: idx = vp_r[26:18];
      2'd2: idx = vp_r[17:9];
      default: idx = vp_r[8:0];
    endcase
  end
  assign addr = {off[SlotW-1:0], idx};
  assign upper = {61'd0, fl_r[2], 2'b11};

  always_comb begin
    we = 1'b0;
    waddr = addr;
    wdata = rdata_r | upper;
    if (cmd.wr_leaf) begin
      we = 1'b1;
      wdata = {1'b0, 11'd0, pf_r, fl_r};
    end else if (cmd.wr_new) begin
      we = 1'b1;
      wdata = {12'd0, new_frame, 12'd0} | upper;
    end else if (cmd.wr_or) begin
      we = 1'b1;
    end else if (cmd.clr_step) begin
      we = 1'b1;
      waddr = {clr_slot_r, clr_idx_r};
      wdata = '0;
    end
  end
  assign nxt_frame = cmd.wr_or ? rdata_r[51:12] : frame_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      query_r <= in_action;
      vp_r <= in_virt_page;
      pf_r <= in_phys_frame;
      fl_r <= in_entry_flags;
      lvl_r <= 2'd0;
      frame_r <= root_frame;
    end else begin
      if (cmd.wr_new) frame_r <= new_frame;
      else if (cmd.next_lvl && query_r) frame_r <= rdata_r[51:12];
      else frame_r <= nxt_frame;
      if (cmd.next_lvl) lvl_r <= lvl_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      clr_slot_r <= '0;
      clr_idx_r <= '0;
    end else begin
      if (cmd.wr_new) used_r <= used_r + 1'b1;
      if (cmd.clr_start) begin
        clr_slot_r <= new_off[SlotW-1:0];
        clr_idx_r <= '0;
      end else if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end
endmodule
